// ----- rtl/pmu_pkg.sv -----
// pmu_pkg: shared constants, item types and controller states
// for the polynomial multiplier unit and its checker
// no dependencies

package pmu_pkg;

    // storage limits
    localparam int MAX_TERMS = 32;
    localparam int PROD_LEN  = 2 * MAX_TERMS - 1;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DEG_W     = 6;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 64;

    // input item: one coefficient pair
    typedef struct packed {
        logic signed [COEF_W-1:0] x_coeff;
        logic signed [COEF_W-1:0] y_coeff;
        logic                     last_pair;
    } t_in_item;

    // result item: one product coefficient
    typedef struct packed {
        logic signed [PROD_W-1:0] product_coeff;
        logic [DEG_W-1:0]         degree;
        logic                     last_result;
    } t_out_item;

    // tag carried down the multiply-accumulate pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             fin;
        logic             last_res;
        logic [DEG_W-1:0] degree;
    } t_tag;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

// ----- rtl/polynomial_multiplier_unit.sv -----
// polynomial_multiplier_unit: loads coefficient pairs into two memories, then
// forms the product by convolution on one multiply-accumulate pipeline
// depends on pmu_pkg
//
//  channel | signals                       | direction | handshake
//  --------+-------------------------------+-----------+---------------------------
//  item in | i_start, o_busy, i_item       | in        | taken when i_start & !o_busy
//  result  | o_strobe, o_result            | out       | shown one cycle, no stall
//
// loading takes a pair whenever the unit is idle; a pair without last_pair gives no result
// after the last pair the unit is busy forming the n*n products (n pairs held): one
// multiply-accumulate per cycle, bounded by the single read port of each store
// results appear in degree order, each for one cycle, with no back-pressure
// synchronous active-low reset clears the pair count and the pipeline control

module polynomial_multiplier_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pmu_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_strobe,
    output pmu_pkg::t_out_item o_result
);

    localparam int IW = pmu_pkg::IDX_W;
    localparam int CW = pmu_pkg::CNT_W;
    localparam int DW = pmu_pkg::DEG_W;

    // coefficient stores
    logic [pmu_pkg::COEF_W-1:0] x_mem [pmu_pkg::MAX_TERMS];
    logic [pmu_pkg::COEF_W-1:0] y_mem [pmu_pkg::MAX_TERMS];

    pmu_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count;
    logic [DW-1:0]   r_k;
    logic [IW-1:0]   r_i;

    logic signed [pmu_pkg::COEF_W-1:0] r_xq, r_yq;
    logic signed [pmu_pkg::PROD_W-1:0] r_prod, r_acc;
    pmu_pkg::t_tag   r_tag1, r_tag2, n_tag1;
    pmu_pkg::t_out_item r_out;
    logic            r_strobe;

    logic            w_accept, w_store, w_issue, w_fin, w_kmax;
    logic [IW-1:0]   w_ilo, w_ihi, w_ilo_next, w_yidx;
    logic [DW-1:0]   w_kmax_val, w_k_next;
    logic signed [pmu_pkg::PROD_W-1:0] w_sum;

    // lowest x index that pairs with a valid y index for degree k
    function automatic logic [IW-1:0] f_ilo(input logic [DW-1:0] k,
                                            input logic [CW-1:0] n);
        logic [DW-1:0] d;
        d = k - DW'(n) + DW'(1);
        return (k >= DW'(n)) ? d[IW-1:0] : '0;
    endfunction

    // handshake and store write
    assign w_accept = i_start && (r_state == pmu_pkg::ST_IDLE);
    assign w_store  = w_accept && (r_count < CW'(pmu_pkg::MAX_TERMS));

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            x_mem[r_count[IW-1:0]] <= i_item.x_coeff;
            y_mem[r_count[IW-1:0]] <= i_item.y_coeff;
        end
        r_xq <= x_mem[r_i];
        r_yq <= y_mem[w_yidx];
    end

    // index generation for the current degree
    always_comb begin
        logic [DW-1:0] nm1;
        logic [DW-1:0] ym;
        nm1        = DW'(r_count) - DW'(1);
        w_ilo      = f_ilo(r_k, r_count);
        w_ihi      = (r_k < DW'(r_count)) ? r_k[IW-1:0] : nm1[IW-1:0];
        ym         = r_k - DW'(r_i);
        w_yidx     = ym[IW-1:0];
        w_kmax_val = DW'({r_count, 1'b0} - (CW + 1)'(2));
        w_k_next   = r_k + DW'(1);
        w_ilo_next = f_ilo(w_k_next, r_count);
        w_fin      = (r_i == w_ihi);
        w_kmax     = (r_k == w_kmax_val);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmu_pkg::ST_IDLE:  if (w_accept && i_item.last_pair) n_state = pmu_pkg::ST_RUN;
            pmu_pkg::ST_RUN:   if (w_fin && w_kmax) n_state = pmu_pkg::ST_DRAIN;
            pmu_pkg::ST_DRAIN: if (!r_tag1.valid && !r_tag2.valid) n_state = pmu_pkg::ST_IDLE;
            default:           n_state = pmu_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_issue         = (r_state == pmu_pkg::ST_RUN);
        o_busy          = (r_state != pmu_pkg::ST_IDLE);
        n_tag1.valid    = w_issue;
        n_tag1.first    = (r_i == w_ilo);
        n_tag1.fin      = w_fin;
        n_tag1.last_res = w_fin && w_kmax;
        n_tag1.degree   = r_k;
    end

    // controller registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmu_pkg::ST_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            if (w_store) begin
                r_count <= r_count + CW'(1);
            end
            if (w_accept && i_item.last_pair) begin
                r_k <= '0;
                r_i <= '0;
            end else if (w_issue) begin
                if (w_fin) begin
                    r_k <= w_k_next;
                    r_i <= w_ilo_next;
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end
            if (r_state == pmu_pkg::ST_DRAIN && n_state == pmu_pkg::ST_IDLE) begin
                r_count <= '0;
            end
        end
    end

    // multiply stage and accumulate stage
    assign w_sum = (r_tag2.first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= r_xq * r_yq;
        if (r_tag2.valid) begin
            r_acc <= w_sum;
        end
        if (r_tag2.valid && r_tag2.fin) begin
            r_out.product_coeff <= w_sum;
            r_out.degree        <= r_tag2.degree;
            r_out.last_result   <= r_tag2.last_res;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1   <= '0;
            r_tag2   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_tag1   <= n_tag1;
            r_tag2   <= r_tag1;
            r_strobe <= r_tag2.valid && r_tag2.fin;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ----- rtl/pmu_checker.sv -----
// pmu_checker: port-level checks on the polynomial multiplier unit
// depends on pmu_pkg; bound to polynomial_multiplier_unit below

module pmu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input pmu_pkg::t_in_item  i_item,
    input logic               o_busy,
    input logic               o_strobe,
    input pmu_pkg::t_out_item o_result
);

    // a last pair starts a multiply
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_item.last_pair |=> o_busy)
        else $error("last pair did not start a multiply");

    // results only come out of a running multiply
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(o_busy))
        else $error("result item outside a multiply");

    // an idle unit shows no result in the next cycle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |=> !o_strobe)
        else $error("result item after idle");

    // nothing follows the highest-degree coefficient
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_result |=> !o_strobe)
        else $error("result item after last result");

endmodule

bind polynomial_multiplier_unit pmu_checker u_pmu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_item   (i_item),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- verif/tb_polynomial_multiplier_unit.sv -----
// tb_polynomial_multiplier_unit: self-checking bench for the polynomial multiplier unit,
// with a directed table and then random polynomials checked against a convolution predictor
// depends on pmu_pkg and polynomial_multiplier_unit

`timescale 1ns / 100ps

module tb_polynomial_multiplier_unit;

    import pmu_pkg::*;

    localparam int RANDOM_ITEMS   = 470;
    localparam int CALM_ITEMS     = 60;
    localparam int DRAIN_CYCLES   = MAX_TERMS * MAX_TERMS + 16;
    localparam int WATCHDOG_LIMIT = 4 * (MAX_TERMS * MAX_TERMS + 40);
    localparam int REPORT_LIMIT   = 10;

    // directed row: pair plus an optional hand-worked degree-0 product
    typedef struct {
        t_in_item          item;
        bit                has_product;
        logic [PROD_W-1:0] product;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_item;
    logic      o_busy;
    logic      o_strobe;
    t_out_item o_result;

    // hand-worked product travels with the item it belongs to
    bit                row_has_product;
    logic [PROD_W-1:0] row_product;

    // predictor state
    logic signed [COEF_W-1:0] x_mem [MAX_TERMS];
    logic signed [COEF_W-1:0] y_mem [MAX_TERMS];
    int                       held;
    t_out_item                product_q [$];

    int   mismatches;
    int   quiet_cycles;
    t_row directed_rows [$];

    polynomial_multiplier_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    // store the pair; on the last pair form the full product by direct convolution
    task automatic predict_product(input t_in_item it, input bit has_p,
                                   input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0]        acc [PROD_LEN];
        logic signed [PROD_W-1:0] xe;
        logic signed [PROD_W-1:0] ye;
        t_out_item                res;
        if (held < MAX_TERMS) begin
            x_mem[held] = it.x_coeff;
            y_mem[held] = it.y_coeff;
            held++;
        end
        if (it.last_pair) begin
            for (int k = 0; k < PROD_LEN; k++) acc[k] = '0;
            for (int i = 0; i < held; i++) begin
                xe = x_mem[i];
                for (int j = 0; j < held; j++) begin
                    ye = y_mem[j];
                    acc[i + j] = acc[i + j] + xe * ye;
                end
            end
            // single-pair rows carry a hand-worked value instead
            if (has_p) acc[0] = p;
            for (int k = 0; k < 2 * held - 1; k++) begin
                res.product_coeff = acc[k];
                res.degree        = DEG_W'(k);
                res.last_result   = (k == 2 * held - 2);
                product_q.push_back(res);
            end
            held = 0;
        end
    endtask

    // results are checked before new items are predicted within the same edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (product_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: coeff %h degree %0d last %0b",
                                 o_result.product_coeff, o_result.degree,
                                 o_result.last_result);
                end else begin
                    want = product_q.pop_front();
                    if (o_result.product_coeff !== want.product_coeff ||
                        o_result.degree !== want.degree ||
                        o_result.last_result !== want.last_result) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                     want.product_coeff, want.degree, want.last_result,
                                     o_result.product_coeff, o_result.degree,
                                     o_result.last_result);
                    end
                end
            end
            if (i_start && !o_busy)
                predict_product(i_item, row_has_product, row_product);
        end
        // watchdog on cycles where nothing moves
        if (o_strobe || (i_start && !o_busy))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_polynomial_multiplier_unit NOT OK");
            $finish;
        end
    end

    // offer one item and hold it until the unit takes it
    task automatic send_pair(input t_in_item it, input bit has_p, input logic [PROD_W-1:0] p);
        i_start         <= 1'b1;
        i_item          <= it;
        row_has_product <= has_p;
        row_product     <= p;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [COEF_W-1:0] x, input logic [COEF_W-1:0] y,
                           input bit last, input bit has_p, input logic [PROD_W-1:0] p);
        t_row r;
        r.item.x_coeff   = x;
        r.item.y_coeff   = y;
        r.item.last_pair = last;
        r.has_product    = has_p;
        r.product        = p;
        directed_rows.push_back(r);
    endtask

    // extremes and bit patterns weighted against plain random values
    function automatic logic [COEF_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return '0;
            4:       return COEF_W'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_in_item it;
        int       n;
        int       sent;
        int       pick;
        bit       gappy;
        bit       first_poly;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_item          = '0;
        row_has_product = 1'b0;
        row_product     = '0;
        held            = 0;
        mismatches      = 0;
        quiet_cycles    = 0;

        // single pairs: degree-0 product worked by hand
        add_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000);
        add_row(32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1, 64'h0000_0000_0000_0001);
        add_row(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 64'h4000_0000_0000_0000);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 64'hC000_0000_8000_0000);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 64'h3FFF_FFFF_0000_0001);
        add_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_8000_0001);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'h0000_0000_0000_0001);
        // three most-negative pairs: middle coefficient wraps past 2^63
        add_row(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, '0);
        add_row(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, '0);
        add_row(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, '0);
        // alternating bit patterns
        add_row(32'hFFFF_FFFF, 32'h5555_5555, 1'b0, 1'b0, '0);
        add_row(32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b1, 1'b0, '0);
        // mixed signs over four pairs
        add_row(32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, '0);
        add_row(32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, '0);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '0);
        add_row(32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[k]) begin
            send_pair(directed_rows[k].item, directed_rows[k].has_product,
                      directed_rows[k].product);
            if ($urandom_range(0, 2) == 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end

        // random polynomials: mostly short, some full, some overflowing the store
        sent       = 0;
        first_poly = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (first_poly || pick < 5)
                n = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
            else if (pick < 10)
                n = MAX_TERMS;
            else if (pick < 20)
                n = $urandom_range(7, MAX_TERMS - 1);
            else
                n = $urandom_range(1, 6);
            first_poly = 1'b0;
            gappy      = $urandom_range(0, 1);
            for (int k = 0; k < n; k++) begin
                it.x_coeff   = pick_coeff();
                it.y_coeff   = pick_coeff();
                it.last_pair = (k == n - 1);
                send_pair(it, 1'b0, '0);
                sent++;
                // no idling in the closing stretch
                if (gappy && sent < RANDOM_ITEMS - CALM_ITEMS &&
                    $urandom_range(0, 3) == 0) begin
                    i_start <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge i_clk);
                end
            end
        end
        i_start <= 1'b0;

        // drain outstanding products, then watch for strays
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && product_q.size() == 0)
            $display("tb_polynomial_multiplier_unit OK");
        else
            $display("tb_polynomial_multiplier_unit NOT OK");
        $finish;
    end

endmodule
